// File: hw/rtl/npa_pkg.sv
// Shared types and constants for the node pool allocator.
`timescale 1ns / 1ps

package npa_pkg;

  localparam int POOL_SIZE_DEF = 1024;
  localparam int KEY_W         = 32;
  localparam int LINK_W        = 11;

  typedef enum logic [1:0] {
    CMD_CREATE = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_GET    = 2'd2,
    CMD_PUT    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_RANGE  = 2'd2,
    STAT_UNUSED = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [LINK_W-1:0] addr;
    logic [KEY_W-1:0]  key;
    logic [LINK_W-1:0] left_link;
    logic [LINK_W-1:0] right_link;
  } req_t;

  typedef struct packed {
    status_t           status;
    logic [LINK_W-1:0] out_addr;
    logic [KEY_W-1:0]  out_key;
    logic [LINK_W-1:0] out_left;
    logic [LINK_W-1:0] out_right;
    logic [LINK_W-1:0] used_count;
  } rsp_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [LINK_W-1:0] left;
    logic [LINK_W-1:0] right;
  } entry_t;

  typedef struct packed {
    logic   busy;
    logic   we;
    entry_t data;
  } sweep_ctl_t;

endpackage

// File: hw/rtl/npa_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module npa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/npa_sweep.sv
// Post-reset sweep that builds the initial free chain in the node memory.
`timescale 1ns / 1ps

module npa_sweep #(
  parameter int POOL_SIZE = npa_pkg::POOL_SIZE_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  output npa_pkg::sweep_ctl_t          ctl,
  output logic [$clog2(POOL_SIZE)-1:0] idx
);

  localparam int AW = $clog2(POOL_SIZE);
  localparam logic [npa_pkg::LINK_W-1:0] NO_LINK = npa_pkg::LINK_W'(POOL_SIZE);

  logic busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (busy) begin
      idx <= idx + AW'(1);
      if (idx == AW'(POOL_SIZE - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_comb begin
    ctl.busy       = busy;
    ctl.we         = busy;
    ctl.data.key   = '1;
    ctl.data.right = NO_LINK;
    // chain each entry to the next one; the last one ends the list
    if (idx == AW'(POOL_SIZE - 1)) begin
      ctl.data.left = NO_LINK;
    end else begin
      ctl.data.left = npa_pkg::LINK_W'(idx) + npa_pkg::LINK_W'(1);
    end
  end

endmodule

// File: hw/rtl/npa_core.sv
// Command sequencer: read, decide, write back, and the result register.
`timescale 1ns / 1ps

module npa_core #(
  parameter int POOL_SIZE = npa_pkg::POOL_SIZE_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  npa_pkg::req_t                 req,
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output npa_pkg::rsp_t                 rsp,
  input  logic [npa_pkg::KEY_W-1:0]     invalid_key,
  input  npa_pkg::sweep_ctl_t           sweep,
  input  logic [$clog2(POOL_SIZE)-1:0]  sweep_idx,
  output logic                          mem_we,
  output logic [$clog2(POOL_SIZE)-1:0]  mem_waddr,
  output npa_pkg::entry_t               mem_wdata,
  output logic                          mem_re,
  output logic [$clog2(POOL_SIZE)-1:0]  mem_raddr,
  input  npa_pkg::entry_t               mem_rdata
);

  localparam int AW = $clog2(POOL_SIZE);
  localparam int LW = npa_pkg::LINK_W;
  localparam logic [LW-1:0] NO_LINK = LW'(POOL_SIZE);

  npa_pkg::state_t state, state_next;
  npa_pkg::req_t   cur;
  logic [LW-1:0]   free_head, free_head_next;
  logic [LW-1:0]   in_use, in_use_next;
  npa_pkg::rsp_t   rsp_next;
  logic            accept, fire;
  logic            core_we;
  logic [AW-1:0]   core_waddr;
  npa_pkg::entry_t core_wdata;
  logic            in_range;

  assign accept   = req_valid && req_ready;
  assign fire     = (state == npa_pkg::S_EXEC) && (!rsp_valid || rsp_ready);
  assign in_range = 32'(cur.addr) < POOL_SIZE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= npa_pkg::S_IDLE;
      free_head <= '0;
      in_use    <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (fire) begin
        free_head <= free_head_next;
        in_use    <= in_use_next;
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur <= req;
    end
    if (fire) begin
      rsp <= rsp_next;
    end
  end

  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    mem_re     = 1'b0;
    mem_raddr  = AW'(req.addr);
    case (state)
      npa_pkg::S_IDLE: begin
        req_ready = !sweep.busy;
        if (req.cmd == npa_pkg::CMD_CREATE) begin
          mem_raddr = AW'(free_head);
        end
        if (accept) begin
          mem_re     = 1'b1;
          state_next = npa_pkg::S_EXEC;
        end
      end
      npa_pkg::S_EXEC: begin
        if (fire) begin
          state_next = npa_pkg::S_IDLE;
        end
      end
      default: state_next = npa_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    free_head_next      = free_head;
    in_use_next         = in_use;
    core_we             = 1'b0;
    core_waddr          = AW'(cur.addr);
    core_wdata.key      = cur.key;
    core_wdata.left     = cur.left_link;
    core_wdata.right    = cur.right_link;
    rsp_next.status     = npa_pkg::STAT_OK;
    rsp_next.out_addr   = NO_LINK;
    rsp_next.out_key    = invalid_key;
    rsp_next.out_left   = NO_LINK;
    rsp_next.out_right  = NO_LINK;
    if (cur.cmd == npa_pkg::CMD_CREATE) begin
      if (32'(in_use) >= POOL_SIZE || 32'(free_head) >= POOL_SIZE) begin
        rsp_next.status = npa_pkg::STAT_FULL;
      end else begin
        core_we           = 1'b1;
        core_waddr        = AW'(free_head);
        free_head_next    = mem_rdata.left;
        in_use_next       = in_use + LW'(1);
        rsp_next.out_addr = free_head;
      end
    end else if (!in_range) begin
      rsp_next.status = npa_pkg::STAT_RANGE;
    end else begin
      case (cur.cmd)
        npa_pkg::CMD_DELETE: begin
          if (mem_rdata.key == invalid_key) begin
            rsp_next.status = npa_pkg::STAT_UNUSED;
          end else begin
            core_we          = 1'b1;
            core_wdata.key   = invalid_key;
            core_wdata.left  = free_head;
            core_wdata.right = NO_LINK;
            free_head_next   = cur.addr;
            if (in_use != '0) begin
              in_use_next = in_use - LW'(1);
            end
          end
        end
        npa_pkg::CMD_GET: begin
          rsp_next.out_key   = mem_rdata.key;
          rsp_next.out_left  = mem_rdata.left;
          rsp_next.out_right = mem_rdata.right;
          if (mem_rdata.key == invalid_key) begin
            rsp_next.status = npa_pkg::STAT_UNUSED;
          end
        end
        default: begin
          core_we = 1'b1;
        end
      endcase
    end
    rsp_next.used_count = in_use_next;
  end

  // the sweep owns the write port until the free chain is built
  always_comb begin
    if (sweep.busy) begin
      mem_we    = sweep.we;
      mem_waddr = sweep_idx;
      mem_wdata = sweep.data;
    end else begin
      mem_we    = core_we && fire;
      mem_waddr = core_waddr;
      mem_wdata = core_wdata;
    end
  end

  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (rst)
    sweep.busy |-> !req_ready)
    else $error("item accepted during the free chain sweep");

  a_accept_to_exec: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == npa_pkg::S_EXEC))
    else $error("accepted item did not enter execution");

  a_fire_gives_rsp: assert property (@(posedge clk) disable iff (rst)
    fire |=> rsp_valid)
    else $error("executed item produced no result");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(in_use) <= POOL_SIZE)
    else $error("in-use count exceeds pool size");

  a_head_held: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(free_head))
    else $error("free head changed without an executing item");

endmodule

// File: hw/rtl/node_pool_free_list_allocator_unit.sv
// Top level of the free-list node pool allocator.
`timescale 1ns / 1ps

// Node pool allocator: a pool of POOL_SIZE tree nodes (key, left link, right
// link) held in one synchronous RAM, with unused entries chained through
// their left links. Each item on req is one command (create, delete, get or
// put) and yields exactly one item on rsp. An item first reads its entry
// from the node RAM (the free head for create, addr otherwise), then in the
// execute state decides, writes the entry back and loads the result register;
// the block takes no new item until the last one has left the execute state,
// and holds that state while the result register is still full and not taken.
// After reset the block sweeps the RAM to build the free chain 0..POOL_SIZE-1
// and accepts no item until that is done; configuration writes are taken at
// all times. invalid_key (reset all ones) marks unused entries; change it only
// while the block is idle. A link value equal to POOL_SIZE means no link.

module node_pool_free_list_allocator_unit #(
  parameter int POOL_SIZE = npa_pkg::POOL_SIZE_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  output logic                      req_ready,
  input  npa_pkg::req_t             req,
  output logic                      rsp_valid,
  input  logic                      rsp_ready,
  output npa_pkg::rsp_t             rsp,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [npa_pkg::KEY_W-1:0] cfg_data
);

  localparam int AW = $clog2(POOL_SIZE);

  logic [npa_pkg::KEY_W-1:0] invalid_key;
  npa_pkg::sweep_ctl_t       sweep;
  logic [AW-1:0]             sweep_idx;
  logic                      mem_we, mem_re;
  logic [AW-1:0]             mem_waddr, mem_raddr;
  npa_pkg::entry_t           mem_wdata, mem_rdata;

  // the single register is always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      invalid_key <= '1;
    end else if (cfg_valid) begin
      invalid_key <= cfg_data;
    end
  end

  // build the free chain after reset
  npa_sweep #(
    .POOL_SIZE(POOL_SIZE)
  ) u_sweep (
    .clk(clk),
    .rst(rst),
    .ctl(sweep),
    .idx(sweep_idx)
  );

  // node storage: key and both links of every entry in one word
  npa_ram #(
    .WIDTH($bits(npa_pkg::entry_t)),
    .DEPTH(POOL_SIZE)
  ) u_ram (
    .clk(clk),
    .we(mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re(mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  // command sequencing, free head, in-use count and the result register
  npa_core #(
    .POOL_SIZE(POOL_SIZE)
  ) u_core (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp),
    .invalid_key(invalid_key),
    .sweep(sweep),
    .sweep_idx(sweep_idx),
    .mem_we(mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_re(mem_re),
    .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata)
  );

endmodule
